// File: hw/rtl/qte_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the quaternion to Euler angle converter.
package qte_pkg;

  // Width of the CORDIC x and y datapath and of the accumulated angle (Q.16).
  localparam int W           = 37;
  localparam int AW          = 21;
  // Width of the square root operand and of its working root register.
  localparam int NW          = 61;
  localparam int RW          = 62;
  // One square root cell per result bit of a 61-bit operand.
  localparam int SQ_CELLS    = 31;
  localparam int STAGE_LIMIT = 24;

  localparam logic signed [AW-1:0] PI_Q16      = 21'sd205887;
  localparam logic signed [15:0]   PI_Q13      = 16'sd25736;
  localparam logic signed [15:0]   HALF_PI_Q13 = 16'sd12868;

  // Operands of the three angle computations.
  typedef struct packed {
    logic signed [W-1:0] sr;
    logic signed [W-1:0] cr;
    logic signed [W-1:0] sy;
    logic signed [W-1:0] cy;
    logic signed [W-1:0] sp;
  } ops_t;

  // State handed from one square root cell to the next.
  typedef struct packed {
    logic [NW-1:0] rem;
    logic [RW-1:0] root;
    ops_t          ops;
  } sqrt_t;

  // State handed from one CORDIC cell to the next.
  typedef struct packed {
    logic signed [W-1:0]  x;
    logic signed [W-1:0]  y;
    logic signed [AW-1:0] ang;
    logic                 zero;
  } vec_t;

  // Arctangent of 2^-idx in Q.16 radians.
  function automatic logic signed [AW-1:0] atan_q16(input int idx);
    logic signed [AW-1:0] a;
    begin
      case (idx)
        0:  a = 21'sd51472;
        1:  a = 21'sd30386;
        2:  a = 21'sd16055;
        3:  a = 21'sd8150;
        4:  a = 21'sd4091;
        5:  a = 21'sd2047;
        6:  a = 21'sd1024;
        7:  a = 21'sd512;
        8:  a = 21'sd256;
        9:  a = 21'sd128;
        10: a = 21'sd64;
        11: a = 21'sd32;
        12: a = 21'sd16;
        13: a = 21'sd8;
        14: a = 21'sd4;
        15: a = 21'sd2;
        16: a = 21'sd1;
        default: a = '0;
      endcase
      return a;
    end
  endfunction

  // Folds a vector in the left half plane into the right one and seeds the angle.
  function automatic vec_t pre_rot(input logic signed [W-1:0] yv,
                                   input logic signed [W-1:0] xv);
    vec_t v;
    begin
      v.zero = (xv == '0) && (yv == '0);
      if (xv < 0) begin
        v.x   = -xv;
        v.y   = -yv;
        v.ang = (yv >= 0) ? PI_Q16 : -PI_Q16;
      end else begin
        v.x   = xv;
        v.y   = yv;
        v.ang = '0;
      end
      return v;
    end
  endfunction

  // Rounds the Q.16 angle to Q2.13 and clamps it to plus or minus lim; a zero vector gives zero.
  function automatic logic signed [15:0] finish(input vec_t v,
                                                input logic signed [15:0] lim);
    logic signed [AW-1:0] s;
    logic signed [AW-1:0] r;
    logic signed [15:0]   q;
    begin
      s = v.ang + AW'(4);
      r = s >>> 3;
      if (v.zero) begin
        q = '0;
      end else if (r > lim) begin
        q = lim;
      end else if (r < -lim) begin
        q = -lim;
      end else begin
        q = 16'(r);
      end
      return q;
    end
  endfunction

endpackage

// File: hw/rtl/quaternion_to_euler_angles.sv
`timescale 1ns / 1ps
// A CORDIC_STAGES above 24 is capped at 24 CORDIC cells per row.
// Throughput: one quaternion per cycle while the output is not stalled; the whole pipeline advances together.
// Stages: three product/sum/square stages, 31 square root cells, one fold stage, one CORDIC
// cell per stage, and the output register. A stalled output holds the pipeline.
// Reset clears the valid chain and the output valid; payload registers are not reset.
module quaternion_to_euler_angles #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_quat_w,
  input  logic signed [15:0] in_quat_x,
  input  logic signed [15:0] in_quat_y,
  input  logic signed [15:0] in_quat_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_roll_angle,
  output logic signed [14:0] out_pitch_angle,
  output logic signed [15:0] out_yaw_angle
);

  localparam int RUN = (CORDIC_STAGES > qte_pkg::STAGE_LIMIT) ?
                       qte_pkg::STAGE_LIMIT : CORDIC_STAGES;
  localparam int L   = 3 + qte_pkg::SQ_CELLS + 1 + RUN;

  logic                 adv;
  logic [L-1:0]         vld_r;
  logic                 out_valid_r;
  logic signed [15:0]   roll_r, yaw_r;
  logic signed [14:0]   pitch_r;
  qte_pkg::ops_t        f_ops;
  logic [qte_pkg::NW-1:0] f_n;
  qte_pkg::sqrt_t       sq_s [0:qte_pkg::SQ_CELLS];
  qte_pkg::vec_t        cv [0:2][0:RUN];
  qte_pkg::vec_t        pre_nxt [0:2];
  logic signed [qte_pkg::W-1:0] cp;
  logic signed [15:0]   pitch_full;

  // The pipeline moves whenever the output register is free or being emptied.
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // Valid bit of each pipeline stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[L-2:0], in_valid};
      out_valid_r <= vld_r[L-1];
    end
  end

  // Operand formation.
  qte_front u_front (
    .clk   (clk),
    .en    (adv),
    .in_w  (in_quat_w),
    .in_x  (in_quat_x),
    .in_y  (in_quat_y),
    .in_z  (in_quat_z),
    .o_ops (f_ops),
    .o_n   (f_n)
  );

  // Square root row, one result bit per cell.
  assign sq_s[0].rem  = f_n;
  assign sq_s[0].root = '0;
  assign sq_s[0].ops  = f_ops;

  for (genvar k = 0; k < qte_pkg::SQ_CELLS; k++) begin : g_sqrt
    qte_sqrt_cell #(.K(k)) u_cell (
      .clk (clk),
      .en  (adv),
      .i_s (sq_s[k]),
      .o_s (sq_s[k+1])
    );
  end

  // Fold stage: roll, pitch and yaw vectors into the right half plane.
  assign cp = $signed(qte_pkg::W'(sq_s[qte_pkg::SQ_CELLS].root));

  always_comb begin
    pre_nxt[0] = qte_pkg::pre_rot(sq_s[qte_pkg::SQ_CELLS].ops.sr,
                                  sq_s[qte_pkg::SQ_CELLS].ops.cr);
    pre_nxt[1] = qte_pkg::pre_rot(sq_s[qte_pkg::SQ_CELLS].ops.sp, cp);
    pre_nxt[2] = qte_pkg::pre_rot(sq_s[qte_pkg::SQ_CELLS].ops.sy,
                                  sq_s[qte_pkg::SQ_CELLS].ops.cy);
  end

  for (genvar j = 0; j < 3; j++) begin : g_row
    always_ff @(posedge clk) begin
      if (adv) begin
        cv[j][0] <= pre_nxt[j];
      end
    end

    // CORDIC row for one angle.
    for (genvar i = 0; i < RUN; i++) begin : g_cell
      qte_cordic_cell #(.IDX(i)) u_cell (
        .clk (clk),
        .en  (adv),
        .i_v (cv[j][i]),
        .o_v (cv[j][i+1])
      );
    end
  end

  // Output register: rounding and clamping.
  assign pitch_full = qte_pkg::finish(cv[1][RUN], qte_pkg::HALF_PI_Q13);

  always_ff @(posedge clk) begin
    if (adv) begin
      roll_r  <= qte_pkg::finish(cv[0][RUN], qte_pkg::PI_Q13);
      pitch_r <= 15'(pitch_full);
      yaw_r   <= qte_pkg::finish(cv[2][RUN], qte_pkg::PI_Q13);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_roll_angle  = roll_r;
  assign out_pitch_angle = pitch_r;
  assign out_yaw_angle   = yaw_r;

`ifndef ASSERT_OFF
  a_hold_chain: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("valid chain moved while the pipeline was held");

  a_last_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[L-1] && adv) |=> out_valid_r)
    else $error("request in the last stage did not reach the output");

  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_pitch_angle <= 15'sd12868 && out_pitch_angle >= -15'sd12868))
    else $error("pitch outside half pi");

  a_roll_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_roll_angle <= 16'sd25736 && out_roll_angle >= -16'sd25736 &&
                     out_yaw_angle <= 16'sd25736 && out_yaw_angle >= -16'sd25736))
    else $error("roll or yaw outside pi");
`endif

endmodule

// File: hw/rtl/qte_front.sv
`timescale 1ns / 1ps
// Product, sum and squaring stages that form the angle operands and the root operand.
module qte_front (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [15:0]        in_w,
  input  logic signed [15:0]        in_x,
  input  logic signed [15:0]        in_y,
  input  logic signed [15:0]        in_z,
  output qte_pkg::ops_t             o_ops,
  output logic [qte_pkg::NW-1:0]    o_n
);

  localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;
  localparam logic [61:0]        ONE_Q60 = 62'd1 << 60;

  logic signed [31:0] wx_r, yz_r, xx_r, yy_r, wz_r, xy_r, zz_r, wy_r, xz_r;
  logic signed [33:0] sr_r, cr_r, sy_r, cy_r, sp_r;
  logic [30:0]        sq_r;
  logic signed [33:0] sr_nxt, cr_nxt, sy_nxt, cy_nxt, sp_nxt, spw;
  logic [30:0]        sq_nxt;
  qte_pkg::ops_t      ops_r;
  logic [qte_pkg::NW-1:0] n_r;

  // Stage one: the nine quaternion products that the sums need.
  always_ff @(posedge clk) begin
    if (en) begin
      wx_r <= in_w * in_x;
      yz_r <= in_y * in_z;
      xx_r <= in_x * in_x;
      yy_r <= in_y * in_y;
      wz_r <= in_w * in_z;
      xy_r <= in_x * in_y;
      zz_r <= in_z * in_z;
      wy_r <= in_w * in_y;
      xz_r <= in_x * in_z;
    end
  end

  // Stage two: sums, the pitch argument saturated to one, and its magnitude.
  always_comb begin
    sr_nxt = (34'(wx_r) + 34'(yz_r)) <<< 1;
    cr_nxt = ONE_Q30 - ((34'(xx_r) + 34'(yy_r)) <<< 1);
    sy_nxt = (34'(wz_r) + 34'(xy_r)) <<< 1;
    cy_nxt = ONE_Q30 - ((34'(yy_r) + 34'(zz_r)) <<< 1);
    spw    = (34'(wy_r) - 34'(xz_r)) <<< 1;
    if (spw > ONE_Q30) begin
      sp_nxt = ONE_Q30;
    end else if (spw < -ONE_Q30) begin
      sp_nxt = -ONE_Q30;
    end else begin
      sp_nxt = spw;
    end
    sq_nxt = (sp_nxt < 0) ? 31'(-sp_nxt) : 31'(sp_nxt);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sr_r <= sr_nxt;
      cr_r <= cr_nxt;
      sy_r <= sy_nxt;
      cy_r <= cy_nxt;
      sp_r <= sp_nxt;
      sq_r <= sq_nxt;
    end
  end

  // Stage three: one minus the squared pitch argument, in Q.60.
  always_ff @(posedge clk) begin
    if (en) begin
      n_r      <= qte_pkg::NW'(ONE_Q60 - 62'(sq_r) * 62'(sq_r));
      ops_r.sr <= qte_pkg::W'(sr_r);
      ops_r.cr <= qte_pkg::W'(cr_r);
      ops_r.sy <= qte_pkg::W'(sy_r);
      ops_r.cy <= qte_pkg::W'(cy_r);
      ops_r.sp <= qte_pkg::W'(sp_r);
    end
  end

  assign o_ops = ops_r;
  assign o_n   = n_r;

endmodule

// File: hw/rtl/qte_sqrt_cell.sv
`timescale 1ns / 1ps
// One digit step of the integer square root, carrying the angle operands alongside.
module qte_sqrt_cell #(
  parameter int K = 0
) (
  input  logic             clk,
  input  logic             en,
  input  qte_pkg::sqrt_t   i_s,
  output qte_pkg::sqrt_t   o_s
);

  localparam int SH = qte_pkg::NW - 1 - 2 * K;
  localparam logic [qte_pkg::RW-1:0] BIT = qte_pkg::RW'(1) << SH;

  logic [qte_pkg::RW-1:0] trial;
  qte_pkg::sqrt_t         s_nxt;
  qte_pkg::sqrt_t         s_r;

  // Subtract the trial value when it fits and shift the root.
  always_comb begin
    trial     = i_s.root + BIT;
    s_nxt.ops = i_s.ops;
    if (qte_pkg::RW'(i_s.rem) >= trial) begin
      s_nxt.rem  = i_s.rem - trial[qte_pkg::NW-1:0];
      s_nxt.root = (i_s.root >> 1) + BIT;
    end else begin
      s_nxt.rem  = i_s.rem;
      s_nxt.root = i_s.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r <= s_nxt;
    end
  end

  assign o_s = s_r;

endmodule

// File: hw/rtl/qte_cordic_cell.sv
`timescale 1ns / 1ps
// One CORDIC vectoring micro-rotation by atan(2^-IDX).
module qte_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic            clk,
  input  logic            en,
  input  qte_pkg::vec_t   i_v,
  output qte_pkg::vec_t   o_v
);

  localparam logic signed [qte_pkg::AW-1:0] ATN = qte_pkg::atan_q16(IDX);

  logic signed [qte_pkg::W-1:0] dx, dy;
  qte_pkg::vec_t                v_nxt;
  qte_pkg::vec_t                v_r;

  // Rotate toward the x axis; y equal to zero takes the negative direction.
  always_comb begin
    dx         = i_v.y >>> IDX;
    dy         = i_v.x >>> IDX;
    v_nxt.zero = i_v.zero;
    if (i_v.y > 0) begin
      v_nxt.x   = i_v.x + dx;
      v_nxt.y   = i_v.y - dy;
      v_nxt.ang = i_v.ang + ATN;
    end else begin
      v_nxt.x   = i_v.x - dx;
      v_nxt.y   = i_v.y + dy;
      v_nxt.ang = i_v.ang - ATN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r <= v_nxt;
    end
  end

  assign o_v = v_r;

endmodule

// File: tb/quaternion_to_euler_angles_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the quaternion to roll, pitch and yaw converter.
module quaternion_to_euler_angles_tb;

  localparam int STAGES    = 16;
  localparam int LATENCY   = 60;
  localparam int WATCHDOG  = 20000;
  localparam longint ONE_Q30 = 64'sd1 << 30;
  localparam longint PI_Q16L = 205887;
  localparam longint PI_Q13L = 25736;
  localparam longint HALF_PI_Q13L = 12868;

  typedef struct {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
  } angles_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic signed [15:0] in_quat_w;
  logic signed [15:0] in_quat_x;
  logic signed [15:0] in_quat_y;
  logic signed [15:0] in_quat_z;
  logic               out_valid;
  logic               out_stall;
  logic signed [15:0] out_roll_angle;
  logic signed [14:0] out_pitch_angle;
  logic signed [15:0] out_yaw_angle;

  angles_t pending_angles[$];
  int      mismatches;
  int      idle_cycles;
  bit      rx_busy_mode;

  quaternion_to_euler_angles #(.CORDIC_STAGES(STAGES)) DUT (.*);

  // Clock with a 2 ns period.
  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Floor shift that does not depend on the shift of a negative value.
  function automatic longint floor_shift(input longint v, input int s);
    if (v < 0) return ~((~v) >>> s);
    return v >>> s;
  endfunction

  function automatic longint int_sqrt(input longint unsigned n);
    longint unsigned rem, root, bits;
    rem = n;
    root = 0;
    bits = 64'd1 << 62;
    while (bits > rem) bits >>= 2;
    while (bits != 0) begin
      if (rem >= root + bits) begin
        rem -= root + bits;
        root = (root >> 1) + bits;
      end else begin
        root >>= 1;
      end
      bits >>= 2;
    end
    return longint'(root);
  endfunction

  // Arctangent in Q2.13 by vectoring rotations, clamped to plus or minus pi.
  function automatic longint vector_angle(input longint yv, input longint xv);
    longint atan_tab[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                             256, 128, 64, 32, 16, 8, 4, 2, 1};
    longint cx, cy, ang, dx, dy, r;
    if (xv == 0 && yv == 0) return 0;
    cx = xv;
    cy = yv;
    ang = 0;
    if (xv < 0) begin
      cx = -xv;
      cy = -yv;
      ang = (yv >= 0) ? PI_Q16L : -PI_Q16L;
    end
    for (int i = 0; i < STAGES; i++) begin
      dx = floor_shift(cy, i);
      dy = floor_shift(cx, i);
      if (cy > 0) begin
        cx += dx; cy -= dy; ang += (i < 17) ? atan_tab[i] : 0;
      end else begin
        cx -= dx; cy += dy; ang -= (i < 17) ? atan_tab[i] : 0;
      end
    end
    r = floor_shift(ang + 4, 3);
    if (r > PI_Q13L) r = PI_Q13L;
    if (r < -PI_Q13L) r = -PI_Q13L;
    return r;
  endfunction

  function automatic angles_t euler_of(input logic signed [15:0] qw, qx, qy, qz);
    longint w, x, y, z, sr, cr, sy, cy, sp, cp, p;
    longint unsigned sq;
    angles_t a;
    w = qw; x = qx; y = qy; z = qz;
    sr = 2 * (w * x + y * z);
    cr = ONE_Q30 - 2 * (x * x + y * y);
    sy = 2 * (w * z + x * y);
    cy = ONE_Q30 - 2 * (y * y + z * z);
    sp = 2 * (w * y - x * z);
    // Pitch argument saturates for quaternions that are not normalized.
    if (sp > ONE_Q30) sp = ONE_Q30;
    if (sp < -ONE_Q30) sp = -ONE_Q30;
    sq = longint'(sp < 0 ? -sp : sp);
    cp = int_sqrt((64'd1 << 60) - sq * sq);
    p = vector_angle(sp, cp);
    if (p > HALF_PI_Q13L) p = HALF_PI_Q13L;
    if (p < -HALF_PI_Q13L) p = -HALF_PI_Q13L;
    a.roll = 16'(vector_angle(sr, cr));
    a.pitch = 15'(p);
    a.yaw = 16'(vector_angle(sy, cy));
    return a;
  endfunction

  // Gap length: mostly short, now and then long.
  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // Sends one request and records the expected angles once it is accepted.
  // Valid stays high afterwards so that the next request can follow directly.
  task automatic send_quat(input logic signed [15:0] qw, qx, qy, qz, input bit idle);
    int gap;
    gap = idle ? gap_len() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_quat_w <= qw;
    in_quat_x <= qx;
    in_quat_y <= qy;
    in_quat_z <= qz;
    do @(posedge clk); while (in_stall);
    pending_angles.push_back(euler_of(qw, qx, qy, qz));
    @(negedge clk);
  endtask

  // Unit quaternion of random direction, with a little noise.
  task automatic send_unit_quat(input bit idle);
    real a, b, c, d, n;
    a = real'($urandom_range(0, 65535)) - 32768.0;
    b = real'($urandom_range(0, 65535)) - 32768.0;
    c = real'($urandom_range(0, 65535)) - 32768.0;
    d = real'($urandom_range(0, 65535)) - 32768.0;
    n = $sqrt(a * a + b * b + c * c + d * d) + 1.0;
    send_quat(16'($rtoi(a / n * 32767.0)), 16'($rtoi(b / n * 32767.0)),
              16'($rtoi(c / n * 32767.0)), 16'($rtoi(d / n * 32767.0)), idle);
  endtask

  // Drops valid and waits until every expected result has come.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_angles.size() != 0) @(negedge clk);
  endtask

  task automatic test_directed();
    send_quat(16'sd32767, 0, 0, 0, 0);
    send_quat(0, 0, 0, 0, 0);
    send_quat(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 0);
    send_quat(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 0);
    send_quat(0, 16'sd32767, 0, 0, 0);
    send_quat(0, 0, 16'sd32767, 0, 0);
    send_quat(0, 0, 0, 16'sd32767, 0);
    send_quat(16'sd23170, 0, 16'sd23170, 0, 0);
    send_quat(16'sd23170, 0, -16'sd23170, 0, 0);
    send_quat(16'sd23170, 16'sd23170, 0, 0, 0);
    send_quat(16'sd23170, -16'sd23170, 0, 0, 0);
    send_quat(16'sd23170, 0, 0, 16'sd23170, 0);
    send_quat(0, 16'sd23170, 0, 16'sd23170, 1);
    send_quat(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, 1);
    send_quat(16'sd1, -16'sd1, 16'sd1, -16'sd1, 1);
    send_quat(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 1);
    send_quat(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 1);
  endtask

  task automatic test_random();
    for (int i = 0; i < 1500; i++) begin
      // Back-to-back bursts alternate with idling stretches.
      if (i % 300 == 150) wait_drained();
      if ($urandom_range(0, 3) == 0) begin
        send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  (i / 100) % 2 == 1);
      end else begin
        send_unit_quat((i / 100) % 2 == 1);
      end
    end
  endtask

  // Receiver stalls at random, with quiet stretches.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0) rx_busy_mode = ~rx_busy_mode;
      if (rx_busy_mode) out_stall <= ($urandom_range(0, 3) == 0) ||
                                     ($urandom_range(0, 60) == 0);
      else out_stall <= 1'b0;
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    angles_t exp_a;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_angles.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result roll=%0d", out_roll_angle);
      end else begin
        exp_a = pending_angles.pop_front();
        if (exp_a.roll !== out_roll_angle || exp_a.pitch !== out_pitch_angle ||
            exp_a.yaw !== out_yaw_angle) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected r=%0d p=%0d y=%0d got r=%0d p=%0d y=%0d",
                     exp_a.roll, exp_a.pitch, exp_a.yaw,
                     out_roll_angle, out_pitch_angle, out_yaw_angle);
        end
      end
    end
  end

  // Watchdog on cycles with no accepted request on either side.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    mismatches = 0;
    idle_cycles = 0;
    rx_busy_mode = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    out_stall = 1'b0;
    in_quat_w = '0;
    in_quat_x = '0;
    in_quat_y = '0;
    in_quat_z = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    wait_drained();
    test_random();
    wait_drained();
    repeat (LATENCY + 10) @(negedge clk);
    if (mismatches == 0 && pending_angles.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/qte_pkg.sv
hw/rtl/qte_front.sv
hw/rtl/qte_sqrt_cell.sv
hw/rtl/qte_cordic_cell.sv
hw/rtl/quaternion_to_euler_angles.sv
tb/quaternion_to_euler_angles_tb.sv
